[sv/murmur_hashed_packet_counter_core_defines.svh]
// Assertion macros shared by the hashed packet counter RTL.
// No dependencies.
`ifndef MURMUR_HASHED_PACKET_COUNTER_CORE_DEFINES_SVH
`define MURMUR_HASHED_PACKET_COUNTER_CORE_DEFINES_SVH
`define MHPC_ASSERT_IMP(lbl, c, a, b) \
  lbl: assert property (@(posedge c) disable iff (a) (b)) else $error("lbl");
`define MHPC_ASSERT_NEXT(lbl, c, a, x, y) \
  lbl: assert property (@(posedge c) disable iff (a) (x) |=> (y)) else $error("lbl");
`endif

[sv/mhpc_pkg.sv]
// Types, constants and hash helpers for the hashed packet counter.
// No dependencies.
`default_nettype none
package mhpc_pkg;
  localparam logic [31:0] C1 = 32'hcc9e2d51;
  localparam logic [31:0] C2 = 32'h1b873593;
  localparam logic [31:0] CN = 32'he6546b64;
  localparam logic [31:0] F1 = 32'h85ebca6b;
  localparam logic [31:0] F2 = 32'hc2b2ae35;
  localparam logic [2:0] REG_PSIZE = 3'd0;
  localparam logic [2:0] REG_KOFF = 3'd1;
  localparam logic [2:0] REG_KSIZE = 3'd2;
  localparam logic [2:0] REG_CCOUNT = 3'd3;
  localparam logic [2:0] REG_SEED = 3'd4;
  localparam logic [2:0] REG_SCOUNT = 3'd5;
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic [2:0] read_row;
    logic [9:0] read_index;
  } in_req_t;

  typedef struct packed {
    logic [31:0] counter_value;
    logic [31:0] packets_seen;
  } out_req_t;

  // control handed along the chain of hash cells
  typedef struct packed {
    logic        go;
    logic [5:0]  blk;
    logic [31:0] word;
  } cell_ctl_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction
endpackage
`default_nettype wire

[sv/mhpc_cell.sv]
// One hash cell of the chain: MurmurHash3 state for one seed row.
// Depends on mhpc_pkg.
`default_nettype none
module mhpc_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire logic [31:0]       seed,
  input  wire mhpc_pkg::cell_ctl_t ctl_in,
  input  wire logic              step_final,
  input  wire logic              tail,
  input  wire logic [6:0]        len,
  output mhpc_pkg::cell_ctl_t    ctl_out,
  output logic [31:0]            h
);
  import mhpc_pkg::*;
  // phase counter within one block: 0 mul c1, 1 mul c2, 2 combine
  logic [1:0]  ph;
  logic [31:0] k;
  logic [2:0]  fph;
  logic [31:0] h_next;
  logic [31:0] k_next;
  always_comb begin
    h_next = h;
    k_next = k;
    if (step_final) begin
      case (fph)
        3'd0: h_next = h ^ {25'd0, len};
        3'd1: h_next = h ^ (h >> 16);
        3'd2: h_next = h * F1;
        3'd3: h_next = h ^ (h >> 13);
        3'd4: h_next = h * F2;
        3'd5: h_next = h ^ (h >> 16);
        default: h_next = h;
      endcase
    end else if (ctl_in.go) begin
      case (ph)
        2'd0: k_next = ctl_in.word * C1;
        2'd1: k_next = rotl(k, 15) * C2;
        2'd2: begin
          if (tail) h_next = h ^ k;
          else h_next = rotl(h ^ k, 13) * 32'd5 + CN;
        end
        default: k_next = k;
      endcase
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= 2'd0;
      fph <= 3'd0;
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
      if (load) begin
        ph <= 2'd0;
        fph <= 3'd0;
      end else if (step_final) begin
        fph <= fph + 3'd1;
      end else if (ctl_in.go) begin
        ph <= (ph == 2'd2) ? 2'd0 : ph + 2'd1;
      end
    end
    if (load) h <= seed;
    else h <= h_next;
    k <= k_next;
  end
endmodule
`default_nettype wire

[sv/mhpc_mod.sv]
// Restoring remainder unit: hash mod counter_count, one bit a cycle.
// Depends on mhpc_pkg.
`default_nettype none
module mhpc_mod (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [10:0] den,
  output logic             done,
  output logic [10:0]      rem
);
  import mhpc_pkg::*;
  logic [31:0] q;
  logic [5:0]  cnt;
  logic        busy;
  logic [11:0] trial;
  assign trial = {rem, q[31]};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (start) begin
      q <= num;
      rem <= '0;
    end else if (busy) begin
      q <= {q[30:0], 1'b0};
      if (trial >= {1'b0, den}) rem <= 11'(trial - {1'b0, den});
      else rem <= trial[10:0];
    end
  end
endmodule
`default_nettype wire

[sv/murmur_hashed_packet_counter_core.sv]
// Top level: framing, key buffer, chain of hash cells, counter memory, APB.
// Depends on mhpc_pkg, mhpc_cell, mhpc_mod and the defines header.
//
// channel  dir  handshake          payload
// in       in   in_valid/in_ready  in_req_t
// out      out  out_valid/out_ready out_req_t
// cfg      in   APB                32-bit registers at 4*i
//
// A byte is accepted while idle; the last byte of a record starts a hash
// in all cells at once, then per row a remainder and a read-modify-write
// through the memory read and write ports. A read is accepted only when
// the output register is free and goes through the memory read port.
// After reset a clearing pass over every memory word (8192 at the
// defaults) holds in_ready low.
`default_nettype none
`include "murmur_hashed_packet_counter_core_defines.svh"
module murmur_hashed_packet_counter_core #(
  parameter int MAX_SEEDS = 8,
  parameter int MAX_COUNTERS = 1024,
  parameter int MAX_KEY_BYTES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mhpc_pkg::in_req_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mhpc_pkg::out_req_t     out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import mhpc_pkg::*;
  localparam int RW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int CW = (MAX_COUNTERS > 1) ? $clog2(MAX_COUNTERS) : 1;
  localparam int AW = RW + CW;
  localparam int DEPTH = MAX_SEEDS * (1 << CW);
  localparam int NB = (MAX_KEY_BYTES + 3) / 4;
  localparam int WW = (NB > 1) ? $clog2(NB) : 1;

  typedef enum logic [7:0] {
    S_CLR  = 8'b00000001,
    S_IDLE = 8'b00000010,
    S_HASH = 8'b00000100,
    S_FIN  = 8'b00001000,
    S_MOD  = 8'b00010000,
    S_RD   = 8'b00100000,
    S_WR   = 8'b01000000,
    S_QRD  = 8'b10000000
  } st_t;
  st_t st;

  logic [15:0] rec_bytes, win_off;
  logic [6:0]  win_len;
  logic [10:0] counter_count;
  logic [31:0] base_seed;
  logic [3:0]  row_count;
  logic [15:0] byte_position;
  logic [31:0] packet_total;
  logic [31:0] kbuf [NB];

  assign pready = 1'b1;
  wire wr_en = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_bytes <= 16'd64;
      win_off <= 16'd0;
      win_len <= 7'd4;
      counter_count <= 11'd1024;
      base_seed <= 32'd0;
      row_count <= 4'd1;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_PSIZE:  rec_bytes <= pwdata[15:0];
        REG_KOFF:   win_off <= pwdata[15:0];
        REG_KSIZE:  win_len <= pwdata[6:0];
        REG_CCOUNT: counter_count <= pwdata[10:0];
        REG_SEED:   base_seed <= pwdata;
        REG_SCOUNT: row_count <= pwdata[3:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[4:2])
      REG_PSIZE:  prdata = {16'd0, rec_bytes};
      REG_KOFF:   prdata = {16'd0, win_off};
      REG_KSIZE:  prdata = {25'd0, win_len};
      REG_CCOUNT: prdata = {21'd0, counter_count};
      REG_SEED:   prdata = base_seed;
      REG_SCOUNT: prdata = {28'd0, row_count};
      default:    prdata = 32'd0;
    endcase
  end

  wire enabled = (win_len != 7'd0) && ({25'd0, win_len} <= 32'(MAX_KEY_BYTES))
    && ({1'b0, win_off} + {10'd0, win_len} <= {1'b0, rec_bytes})
    && (counter_count != 11'd0) && ({21'd0, counter_count} <= 32'(MAX_COUNTERS))
    && (row_count != 4'd0) && ({28'd0, row_count} <= 32'(MAX_SEEDS));

  // output register
  logic out_full;
  assign out_valid = out_full;
  wire out_free = !out_full || out_ready;

  wire acc = in_valid && in_ready;
  assign in_ready = (st == S_IDLE) && (in_data.op == OP_BYTE || out_free);

  wire [16:0] pos1 = {1'b0, byte_position} + 17'd1;
  wire last = (rec_bytes != 16'd0) && (pos1 >= {1'b0, rec_bytes});
  wire [16:0] kidx = {1'b0, byte_position} - {1'b0, win_off};
  wire in_key = (byte_position >= win_off) && (kidx < {10'd0, win_len})
    && (kidx < 17'(MAX_KEY_BYTES));

  // hash sequencing
  logic [5:0]  blk;
  logic [1:0]  ph;
  logic [2:0]  fcnt;
  logic [3:0]  row;
  logic [5:0]  nblk;
  logic        has_tail;
  logic        load;
  assign nblk = 6'(win_len >> 2);
  assign has_tail = win_len[1:0] != 2'd0;
  wire [5:0] nb_all = nblk + {5'd0, has_tail};

  // key words: byte writes, registered read one block ahead
  wire [5:0] rd_blk = (st == S_HASH && !load && ph == 2'd2) ? blk + 6'd1 : blk;
  logic [31:0] kword;
  always_ff @(posedge clk) begin
    if (acc && in_data.op == OP_BYTE && rec_bytes != 16'd0 && in_key)
      kbuf[WW'(kidx >> 2)][{kidx[1:0], 3'b000} +: 8] <= in_data.data_byte;
    kword <= kbuf[WW'(rd_blk)];
  end

  logic [31:0] word;
  always_comb begin
    word = kword;
    for (int j = 0; j < 4; j++) begin
      if (({blk, 2'b00} + 8'(j)) >= {1'b0, win_len}) word[8*j +: 8] = 8'd0;
    end
  end

  cell_ctl_t lead;
  assign lead.go = (st == S_HASH);
  assign lead.blk = blk;
  assign lead.word = word;
  wire step_final = (st == S_FIN);
  wire tail = has_tail && (blk == nblk);

  cell_ctl_t ctl [MAX_SEEDS+1];
  logic [31:0] hv [MAX_SEEDS];
  assign ctl[0] = lead;
  for (genvar g = 0; g < MAX_SEEDS; g++) begin : g_cell
    cell_ctl_t cin;
    assign cin = '{go: lead.go, blk: ctl[g].blk, word: lead.word};
    mhpc_cell u_cell (
      .clk(clk), .rst(rst), .load(load), .seed(base_seed + 32'(g)),
      .ctl_in(cin), .step_final(step_final), .tail(tail), .len(win_len),
      .ctl_out(ctl[g+1]), .h(hv[g])
    );
  end

  logic        mstart, mdone;
  logic [10:0] mrem;
  mhpc_mod u_mod (
    .clk(clk), .rst(rst), .start(mstart), .num(hv[RW'(row)]),
    .den(counter_count), .done(mdone), .rem(mrem)
  );

  // counter memory
  logic [31:0] mem [DEPTH];
  logic [AW-1:0] clr_addr, rd_addr, wr_addr;
  logic [31:0] rd_q;
  logic        rd_oor;
  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
    if (st == S_CLR) mem[clr_addr] <= '0;
    else if (st == S_WR) mem[wr_addr] <= rd_q + 32'd1;
  end
  always_comb begin
    if (st == S_IDLE)
      rd_addr = {RW'(in_data.read_row), CW'(in_data.read_index)};
    else
      rd_addr = {RW'(row), CW'(mrem)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_CLR;
      clr_addr <= '0;
      byte_position <= '0;
      packet_total <= '0;
      out_full <= 1'b0;
      blk <= '0;
      ph <= '0;
      fcnt <= '0;
      row <= '0;
      load <= 1'b0;
      mstart <= 1'b0;
    end else begin
      load <= 1'b0;
      mstart <= 1'b0;
      if (out_full && out_ready) out_full <= 1'b0;
      case (st)
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (int'(clr_addr) == DEPTH - 1) st <= S_IDLE;
        end
        S_IDLE: begin
          if (acc && in_data.op == OP_READ) begin
            rd_oor <= (int'(in_data.read_row) >= MAX_SEEDS)
              || (int'(in_data.read_index) >= MAX_COUNTERS);
            st <= S_QRD;
          end else if (acc) begin
            if (rec_bytes == 16'd0) byte_position <= '0;
            else if (last) begin
              byte_position <= '0;
              packet_total <= packet_total + 32'd1;
              if (enabled) begin
                load <= 1'b1;
                blk <= '0;
                ph <= '0;
                fcnt <= '0;
                row <= '0;
                st <= S_HASH;
              end
            end else byte_position <= pos1[15:0];
          end
        end
        S_QRD: begin
          out_full <= 1'b1;
          out_data.counter_value <= rd_oor ? 32'd0 : rd_q;
          out_data.packets_seen <= packet_total;
          st <= S_IDLE;
        end
        S_HASH: begin
          if (load || nb_all == 6'd0) begin
            if (nb_all == 6'd0) st <= S_FIN;
          end else if (ph == 2'd2) begin
            ph <= '0;
            blk <= blk + 6'd1;
            if (blk + 6'd1 == nb_all) st <= S_FIN;
          end else ph <= ph + 2'd1;
        end
        S_FIN: begin
          fcnt <= fcnt + 3'd1;
          if (fcnt == 3'd5) begin
            mstart <= 1'b1;
            st <= S_MOD;
          end
        end
        S_MOD: if (mdone) st <= S_RD;
        S_RD: begin
          wr_addr <= {RW'(row), CW'(mrem)};
          st <= S_WR;
        end
        S_WR: begin
          if (row + 4'd1 == row_count) st <= S_IDLE;
          else begin
            row <= row + 4'd1;
            mstart <= 1'b1;
            st <= S_MOD;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `MHPC_ASSERT_IMP(a_ready_idle, clk, rst, in_ready |-> st == S_IDLE)
  `MHPC_ASSERT_NEXT(a_read_out, clk, rst, acc && in_data.op == OP_READ, st == S_QRD)
  `MHPC_ASSERT_NEXT(a_out_set, clk, rst, st == S_QRD, out_full)
endmodule
`default_nettype wire
